// ===== sv/sfpc_pkg.sv =====
// Shared types, codes and reset values of the stepper focuser position controller.
`timescale 1ns / 1ps

package sfpc_pkg;

   localparam int PERIOD_W = 20;
   localparam int STEP_W   = 16;
   localparam int POS_W    = 32;
   localparam int TIME_W   = 32;
   localparam int CSR_W    = 32;
   localparam int CSR_IDX_W = 3;
   localparam int OP_W     = 3;
   localparam int MODE_W   = 2;

   // request tdata: value, limit_pressed, padded to whole bytes
   localparam int REQ_DATA_W = 40;
   // response tdata: seven fields, padded to whole bytes
   localparam int RSP_DATA_W = 72;

   localparam logic [PERIOD_W-1:0] HOMING_PERIOD_RST = PERIOD_W'(5000);
   localparam logic [PERIOD_W-1:0] MOVING_PERIOD_RST = PERIOD_W'(2000);
   localparam logic [PERIOD_W-1:0] DEBOUNCE_RST      = PERIOD_W'(50000);
   localparam logic [STEP_W-1:0]   BUTTON_STEP_RST   = STEP_W'(100);

   localparam logic DIR_INWARD  = 1'b0;
   localparam logic DIR_OUTWARD = 1'b1;

   // external mode codes
   localparam logic [MODE_W-1:0] MODE_CODE_HOMING = 2'd0;
   localparam logic [MODE_W-1:0] MODE_CODE_MOVING = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CODE_IDLE   = 2'd2;

   typedef enum logic [2:0] {
      MODE_HOMING = 3'b001,
      MODE_MOVING = 3'b010,
      MODE_IDLE   = 3'b100
   } mode_type;

   typedef enum logic [OP_W-1:0] {
      OP_TICK     = 3'd0,
      OP_MOVE_ABS = 3'd1,
      OP_MOVE_REL = 3'd2,
      OP_HOME     = 3'd3,
      OP_ABORT    = 3'd4,
      OP_BTN_UP   = 3'd5,
      OP_BTN_DOWN = 3'd6
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_HOMING_PERIOD = 3'd0,
      CSR_MOVING_PERIOD = 3'd1,
      CSR_DEBOUNCE      = 3'd2,
      CSR_BUTTON_STEP   = 3'd3,
      CSR_RESYNC_EN     = 3'd4,
      CSR_HOME_POSITION = 3'd5
   } csr_index_type;

   function automatic logic [MODE_W-1:0] mode_code(input mode_type m);
      logic [MODE_W-1:0] code;
      unique case (m)
         MODE_HOMING: code = MODE_CODE_HOMING;
         MODE_MOVING: code = MODE_CODE_MOVING;
         default:     code = MODE_CODE_IDLE;
      endcase
      return code;
   endfunction

endpackage

// ===== sv/stepper_focuser_position_control_core.sv =====
// Top level: stepper focuser position controller with homing and limit resync.
// A word accepted on req waits in the input register; its result goes to the result register, which drives rsp.
// Throughput: one word per cycle unless rsp stalls; the state update for a word fits between the two registers.
// Back-pressure on rsp stalls the input register only when the result register is still full.
// Reset (synchronous, active high) sets homing mode, position and target zero, step low,
// direction inward, timers cleared and all configuration registers to their defaults.
`timescale 1ns / 1ps

module stepper_focuser_position_control_core
   import sfpc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // [31:0] value, [32] limit_pressed, rest zero
   input  logic [OP_W-1:0]       req_tuser,  // [2:0] op
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [0] step_level, [1] dir_out, [2] driver_enable, [4:3] mode, [36:5] position,
   // [68:37] target_position, [69] resynced, rest zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_W-1:0]      csr_wdata
);

   // configuration
   logic [PERIOD_W-1:0] homing_period_ff, moving_period_ff, debounce_ff;
   logic [STEP_W-1:0]   button_step_ff;
   logic                resync_en_ff;
   logic [POS_W-1:0]    home_position_ff;

   // input register
   logic             in_valid_ff;
   op_type           in_op_ff;
   logic [POS_W-1:0] in_value_ff;
   logic             in_limit_ff;

   // controller state
   mode_type            mode_ff, mode_in;
   logic [POS_W-1:0]    position_ff, position_in;
   logic [POS_W-1:0]    target_ff, target_in;
   logic                dir_ff, dir_in;
   logic                step_ff, step_in;
   logic [PERIOD_W-1:0] prescale_ff, prescale_in;
   logic [TIME_W-1:0]   time_ff, time_in;
   logic [TIME_W-1:0]   last_resync_ff, last_resync_in;
   logic                latched_ff, latched_in;
   logic                resynced;

   // result register
   logic                  out_valid_ff;
   logic [RSP_DATA_W-1:0] out_data_ff;

   logic advance;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         homing_period_ff <= HOMING_PERIOD_RST;
         moving_period_ff <= MOVING_PERIOD_RST;
         debounce_ff      <= DEBOUNCE_RST;
         button_step_ff   <= BUTTON_STEP_RST;
         resync_en_ff     <= 1'b1;
         home_position_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_HOMING_PERIOD: homing_period_ff <= csr_wdata[PERIOD_W-1:0];
            CSR_MOVING_PERIOD: moving_period_ff <= csr_wdata[PERIOD_W-1:0];
            CSR_DEBOUNCE:      debounce_ff      <= csr_wdata[PERIOD_W-1:0];
            CSR_BUTTON_STEP:   button_step_ff   <= csr_wdata[STEP_W-1:0];
            CSR_RESYNC_EN:     resync_en_ff     <= csr_wdata[0];
            CSR_HOME_POSITION: home_position_ff <= csr_wdata[POS_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_op_ff    <= op_type'(req_tuser);
         in_value_ff <= req_tdata[POS_W-1:0];
         in_limit_ff <= req_tdata[POS_W];
      end
   end

   always_comb begin
      logic [PERIOD_W-1:0] period;
      logic [PERIOD_W:0]   count_inc;
      logic                half_step;
      logic                pulse;
      logic                target_write;
      logic [POS_W-1:0]    next_target;

      mode_in        = mode_ff;
      position_in    = position_ff;
      target_in      = target_ff;
      dir_in         = dir_ff;
      step_in        = step_ff;
      prescale_in    = prescale_ff;
      time_in        = time_ff;
      last_resync_in = last_resync_ff;
      latched_in     = latched_ff;
      resynced       = 1'b0;
      half_step      = 1'b0;
      pulse          = 1'b0;
      target_write   = 1'b0;
      next_target    = target_ff;

      period    = (mode_ff == MODE_HOMING) ? homing_period_ff : moving_period_ff;
      if (period == '0) begin
         period = PERIOD_W'(1);
      end
      count_inc = {1'b0, prescale_ff} + (PERIOD_W+1)'(1);

      case (in_op_ff)
         OP_TICK: begin
            time_in = time_ff + TIME_W'(1);
            if (mode_ff != MODE_IDLE) begin
               if (count_inc >= {1'b0, period}) begin
                  prescale_in = '0;
                  half_step   = 1'b1;
               end else begin
                  prescale_in = count_inc[PERIOD_W-1:0];
               end
            end
         end
         OP_MOVE_ABS: begin
            if (in_value_ff != position_ff) begin
               target_write = 1'b1;
               next_target  = in_value_ff;
               mode_in      = MODE_MOVING;
               prescale_in  = '0;
            end
         end
         OP_MOVE_REL: begin
            if (in_value_ff != '0) begin
               target_write = 1'b1;
               next_target  = target_ff + in_value_ff;
               mode_in      = MODE_MOVING;
               prescale_in  = '0;
            end
         end
         OP_HOME: begin
            mode_in     = MODE_HOMING;
            prescale_in = '0;
         end
         OP_ABORT: begin
            mode_in     = MODE_IDLE;
            prescale_in = '0;
            target_in   = position_ff;
         end
         OP_BTN_UP: begin
            target_write = 1'b1;
            next_target  = target_ff + {{(POS_W-STEP_W){1'b0}}, button_step_ff};
         end
         OP_BTN_DOWN: begin
            target_write = 1'b1;
            next_target  = target_ff - {{(POS_W-STEP_W){1'b0}}, button_step_ff};
         end
         default: ;
      endcase

      // direction follows the target only when it actually moves
      if (target_write) begin
         if ($signed(next_target) > $signed(target_ff)) begin
            dir_in = DIR_OUTWARD;
         end else if ($signed(next_target) < $signed(target_ff)) begin
            dir_in = DIR_INWARD;
         end
         target_in = next_target;
      end

      if (half_step) begin
         pulse = 1'b1;
         if (mode_ff == MODE_HOMING) begin
            dir_in = DIR_INWARD;
            if (in_limit_ff) begin
               mode_in     = MODE_IDLE;
               position_in = home_position_ff;
               target_in   = home_position_ff;
               pulse       = 1'b0;
            end
         end else begin
            if ($signed(position_ff) > $signed(target_ff)) begin
               dir_in = DIR_INWARD;
            end else if ($signed(position_ff) < $signed(target_ff)) begin
               dir_in = DIR_OUTWARD;
            end else begin
               mode_in = MODE_IDLE;
               pulse   = 1'b0;
            end
            // fresh, debounced press while driving inward zeroes the count
            if (resync_en_ff) begin
               if (dir_in == DIR_INWARD && in_limit_ff && !latched_ff &&
                   (time_in - last_resync_ff) >= {{(TIME_W-PERIOD_W){1'b0}}, debounce_ff}) begin
                  latched_in     = 1'b1;
                  last_resync_in = time_in;
                  position_in    = '0;
                  resynced       = 1'b1;
               end
               if (!in_limit_ff) begin
                  latched_in = 1'b0;
               end
            end
         end
      end

      // count on the rising edge of the step line
      if (pulse) begin
         step_in = !step_ff;
         if (step_in) begin
            position_in = (dir_in == DIR_OUTWARD) ? position_in + POS_W'(1)
                                                  : position_in - POS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_HOMING;
         position_ff    <= '0;
         target_ff      <= '0;
         dir_ff         <= DIR_INWARD;
         step_ff        <= 1'b0;
         prescale_ff    <= '0;
         time_ff        <= '0;
         last_resync_ff <= '0;
         latched_ff     <= 1'b0;
      end else if (advance) begin
         mode_ff        <= mode_in;
         position_ff    <= position_in;
         target_ff      <= target_in;
         dir_ff         <= dir_in;
         step_ff        <= step_in;
         prescale_ff    <= prescale_in;
         time_ff        <= time_in;
         last_resync_ff <= last_resync_in;
         latched_ff     <= latched_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= {2'b00, resynced, target_in, position_in, mode_code(mode_in),
                         mode_in != MODE_IDLE, dir_in, step_in};
      end
   end

`ifndef SYNTHESIS
   a_idle_prescale_clear: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_IDLE) |-> (prescale_ff == '0))
      else $error("prescaler running while idle");

   a_resync_position: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[69]) |->
         ((rsp_tdata[36:5] == 32'h0 || rsp_tdata[36:5] == 32'hFFFF_FFFF) && !rsp_tdata[1]))
      else $error("resync result with position away from zero or outward direction");

   a_state_holds_without_advance: assert property (@(posedge clock) disable iff (reset)
      !advance |=> ($stable(position_ff) && $stable(target_ff) && $stable(time_ff)))
      else $error("controller state changed without a word advancing");
`endif

endmodule

// ===== bench/tb_stepper_focuser_position_control_core.sv =====
// Self-checking bench for the stepper focuser core: directed and random words against a predictor.
`timescale 1ns / 1ps

module tb_stepper_focuser_position_control_core
   import sfpc_pkg::*;
;

   localparam int STALL_LIMIT  = 2000;
   localparam int PHASE_COUNT  = 8;
   localparam int PHASE_WORDS  = 128;
   localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic [31:0]     value;
      logic            limit;
   } focus_word_type;

   typedef struct packed {
      logic              step;
      logic              dir;
      logic              en;
      logic [MODE_W-1:0] mode;
      logic [POS_W-1:0]  pos;
      logic [POS_W-1:0]  tgt;
      logic              resynced;
   } focus_state_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [OP_W-1:0]       req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_W-1:0]      csr_wdata = '0;

   stepper_focuser_position_control_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // configuration mirror
   logic [PERIOD_W-1:0] cfg_homing_period = HOMING_PERIOD_RST;
   logic [PERIOD_W-1:0] cfg_moving_period = MOVING_PERIOD_RST;
   logic [PERIOD_W-1:0] cfg_debounce      = DEBOUNCE_RST;
   logic [STEP_W-1:0]   cfg_button_step   = BUTTON_STEP_RST;
   logic                cfg_resync_en     = 1'b1;
   logic [POS_W-1:0]    cfg_home_position = '0;

   // predicted controller state
   logic [MODE_W-1:0]   m_mode    = MODE_CODE_HOMING;
   logic [POS_W-1:0]    m_pos     = '0;
   logic [POS_W-1:0]    m_tgt     = '0;
   logic                m_dir     = DIR_INWARD;
   logic                m_step    = 1'b0;
   logic [PERIOD_W-1:0] m_presc   = '0;
   logic [TIME_W-1:0]   m_time    = '0;
   logic [TIME_W-1:0]   m_last_rs = '0;
   logic                m_latched = 1'b0;

   focus_word_type  words_to_send[$];
   focus_state_type focuser_outputs_due[$];
   focus_word_type  presented;
   focus_state_type got, want;

   int items_queued  = 0;
   int results_seen  = 0;
   int mismatches    = 0;
   int resync_count  = 0;
   int homing_stops  = 0;
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int stuck_cycles  = 0;

   task automatic retarget(input logic [POS_W-1:0] t);
      if ($signed(t) > $signed(m_tgt))
         m_dir = DIR_OUTWARD;
      else if ($signed(m_tgt) > $signed(t))
         m_dir = DIR_INWARD;
      m_tgt = t;
   endtask

   task automatic advance_focuser(input focus_word_type w);
      logic [31:0]     per;
      logic            pulse;
      logic            resync_now;
      focus_state_type st;
      resync_now = 1'b0;
      case (w.op)
         OP_TICK: begin
            m_time = m_time + 1;
            if (m_mode != MODE_CODE_IDLE) begin
               per = (m_mode == MODE_CODE_HOMING) ? {12'b0, cfg_homing_period}
                                                  : {12'b0, cfg_moving_period};
               if (per == 0)
                  per = 1;
               if ({12'b0, m_presc} + 32'd1 >= per) begin
                  m_presc = '0;
                  pulse = 1'b1;
                  if (m_mode == MODE_CODE_HOMING) begin
                     m_dir = DIR_INWARD;
                     if (w.limit) begin
                        m_mode = MODE_CODE_IDLE;
                        m_pos  = cfg_home_position;
                        m_tgt  = cfg_home_position;
                        pulse  = 1'b0;
                        homing_stops++;
                     end
                  end else begin
                     if ($signed(m_pos) > $signed(m_tgt))
                        m_dir = DIR_INWARD;
                     else if ($signed(m_tgt) > $signed(m_pos))
                        m_dir = DIR_OUTWARD;
                     else begin
                        // target reached: stop without a pulse
                        m_mode = MODE_CODE_IDLE;
                        pulse  = 1'b0;
                     end
                     if (cfg_resync_en) begin
                        if (m_dir == DIR_INWARD && w.limit && !m_latched &&
                            (m_time - m_last_rs) >= {12'b0, cfg_debounce}) begin
                           m_latched  = 1'b1;
                           m_last_rs  = m_time;
                           m_pos      = '0;
                           resync_now = 1'b1;
                           resync_count++;
                        end
                        if (!w.limit)
                           m_latched = 1'b0;
                     end
                  end
                  if (pulse) begin
                     m_step = ~m_step;
                     if (m_step)
                        m_pos = (m_dir == DIR_OUTWARD) ? m_pos + 1 : m_pos - 1;
                  end
               end else begin
                  m_presc = m_presc + 1'b1;
               end
            end
         end
         OP_MOVE_ABS: begin
            if (w.value != m_pos) begin
               retarget(w.value);
               m_mode  = MODE_CODE_MOVING;
               m_presc = '0;
            end
         end
         OP_MOVE_REL: begin
            if (w.value != 0) begin
               retarget(m_tgt + w.value);
               m_mode  = MODE_CODE_MOVING;
               m_presc = '0;
            end
         end
         OP_HOME: begin
            m_mode  = MODE_CODE_HOMING;
            m_presc = '0;
         end
         OP_ABORT: begin
            m_mode  = MODE_CODE_IDLE;
            m_presc = '0;
            m_tgt   = m_pos;
         end
         OP_BTN_UP:   retarget(m_tgt + {16'b0, cfg_button_step});
         OP_BTN_DOWN: retarget(m_tgt - {16'b0, cfg_button_step});
         default: ;
      endcase
      st.step     = m_step;
      st.dir      = m_dir;
      st.en       = (m_mode != MODE_CODE_IDLE);
      st.mode     = m_mode;
      st.pos      = m_pos;
      st.tgt      = m_tgt;
      st.resynced = resync_now;
      focuser_outputs_due.push_back(st);
   endtask

   // driver: hold a word until taken, then fetch the next one
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            advance_focuser(presented);
         if (!req_tvalid || req_tready) begin
            if (words_to_send.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               presented = words_to_send.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {{(REQ_DATA_W-33){1'b0}}, presented.limit, presented.value};
               req_tuser  <= presented.op;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor: compare each result word with the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            got.step     = rsp_tdata[0];
            got.dir      = rsp_tdata[1];
            got.en       = rsp_tdata[2];
            got.mode     = rsp_tdata[4:3];
            got.pos      = rsp_tdata[36:5];
            got.tgt      = rsp_tdata[68:37];
            got.resynced = rsp_tdata[69];
            if (focuser_outputs_due.size() == 0) begin
               if (mismatches < 10)
                  $display("%0t: result word with nothing predicted: %h", $realtime, rsp_tdata);
               mismatches++;
            end else begin
               want = focuser_outputs_due.pop_front();
               if (got.step !== want.step || got.dir !== want.dir || got.en !== want.en ||
                   got.mode !== want.mode || got.pos !== want.pos || got.tgt !== want.tgt ||
                   got.resynced !== want.resynced) begin
                  if (mismatches < 10) begin
                     $display("%0t: word %0d step %b/%b dir %b/%b en %b/%b mode %0d/%0d",
                              $realtime, results_seen, want.step, got.step, want.dir,
                              got.dir, want.en, got.en, want.mode, got.mode);
                     $display("   pos %h/%h tgt %h/%h resync %b/%b (expected/actual)",
                              want.pos, got.pos, want.tgt, got.tgt, want.resynced,
                              got.resynced);
                  end
                  mismatches++;
               end
            end
         end
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // count cycles with work outstanding but no word moving
   always @(posedge clock) begin
      if (reset || results_seen >= items_queued || (req_tvalid && req_tready) ||
          (rsp_tvalid && rsp_tready))
         stuck_cycles <= 0;
      else
         stuck_cycles <= stuck_cycles + 1;
   end

   initial begin
      wait (stuck_cycles >= STALL_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
   end

   task automatic write_csr(input csr_index_type idx, input logic [CSR_W-1:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_HOMING_PERIOD: cfg_homing_period = data[PERIOD_W-1:0];
         CSR_MOVING_PERIOD: cfg_moving_period = data[PERIOD_W-1:0];
         CSR_DEBOUNCE:      cfg_debounce      = data[PERIOD_W-1:0];
         CSR_BUTTON_STEP:   cfg_button_step   = data[STEP_W-1:0];
         CSR_RESYNC_EN:     cfg_resync_en     = data[0];
         CSR_HOME_POSITION: cfg_home_position = data[POS_W-1:0];
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic apply_setting(input logic [31:0] homing_per, input logic [31:0] moving_per,
                                input logic [31:0] debounce, input logic [31:0] btn_step,
                                input logic [31:0] resync_en, input logic [31:0] home_pos);
      write_csr(CSR_HOMING_PERIOD, homing_per);
      write_csr(CSR_MOVING_PERIOD, moving_per);
      write_csr(CSR_DEBOUNCE, debounce);
      write_csr(CSR_BUTTON_STEP, btn_step);
      write_csr(CSR_RESYNC_EN, resync_en);
      write_csr(CSR_HOME_POSITION, home_pos);
   endtask

   task automatic queue_word(input logic [OP_W-1:0] op, input logic [31:0] value,
                             input logic limit);
      focus_word_type w;
      w.op    = op;
      w.value = value;
      w.limit = limit;
      words_to_send.push_back(w);
      items_queued++;
   endtask

   task automatic wait_drained();
      wait (results_seen >= items_queued);
      repeat (4) @(posedge clock);
   endtask

   // at most one command, then a run of ticks with occasional limit-switch bursts
   task automatic queue_episode();
      int          pick;
      int          run;
      int          lim_left;
      logic [31:0] offset;
      pick     = $urandom_range(99);
      offset   = $urandom_range(80) - 40;
      lim_left = 0;
      if (pick < 30)
         queue_word(OP_MOVE_REL, offset, 1'($urandom_range(1)));
      else if (pick < 45)
         queue_word(OP_MOVE_ABS, offset, 1'($urandom_range(1)));
      else if (pick < 55)
         queue_word(OP_HOME, $urandom(), 1'($urandom_range(1)));
      else if (pick < 63)
         queue_word(OP_ABORT, $urandom(), 1'($urandom_range(1)));
      else if (pick < 73)
         queue_word($urandom_range(1) ? OP_BTN_UP : OP_BTN_DOWN, $urandom(),
                    1'($urandom_range(1)));
      else if (pick < 78)
         queue_word(OP_UNUSED, $urandom(), 1'($urandom_range(1)));
      else if (pick < 85)
         queue_word($urandom_range(1) ? OP_MOVE_ABS : OP_MOVE_REL, $urandom(), 1'b0);
      run = $urandom_range(40);
      repeat (run) begin
         if (lim_left == 0 && $urandom_range(99) < 10)
            lim_left = $urandom_range(6, 1);
         queue_word(OP_TICK, $urandom(), lim_left > 0);
         if (lim_left > 0)
            lim_left--;
      end
   endtask

   int          phase;
   int          base;
   logic [31:0] home_pick;

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: zero homing period, debounce window, stop half-step, wrap extremes
      apply_setting(0, 1, 5, 65535, 1, 3);
      queue_word(OP_TICK, 32'h0, 1'b0);
      queue_word(OP_TICK, 32'hFFFF_FFFF, 1'b0);
      queue_word(OP_TICK, 32'h0, 1'b1);
      queue_word(OP_UNUSED, 32'hFFFF_FFFF, 1'b1);
      queue_word(OP_MOVE_ABS, 32'd3, 1'b0);
      queue_word(OP_MOVE_REL, 32'd0, 1'b0);
      queue_word(OP_MOVE_ABS, -32'sd2, 1'b0);
      queue_word(OP_TICK, 32'h0, 1'b1);
      queue_word(OP_TICK, 32'h0, 1'b0);
      queue_word(OP_TICK, 32'h0, 1'b1);
      queue_word(OP_TICK, 32'h0, 1'b1);
      queue_word(OP_TICK, 32'h0, 1'b1);
      queue_word(OP_TICK, 32'h0, 1'b0);
      queue_word(OP_BTN_UP, 32'h0, 1'b0);
      queue_word(OP_BTN_DOWN, 32'h0, 1'b0);
      queue_word(OP_MOVE_REL, 32'h7FFF_FFFF, 1'b0);
      queue_word(OP_TICK, 32'h0, 1'b0);
      queue_word(OP_TICK, 32'h0, 1'b0);
      queue_word(OP_MOVE_ABS, 32'h8000_0000, 1'b0);
      queue_word(OP_TICK, 32'h0, 1'b1);
      queue_word(OP_ABORT, 32'h0, 1'b0);
      queue_word(OP_TICK, 32'h0, 1'b0);
      queue_word(OP_HOME, 32'h0, 1'b0);
      queue_word(OP_TICK, 32'h0, 1'b0);
      queue_word(OP_TICK, 32'h0, 1'b1);
      wait_drained();

      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0: apply_setting(1, 0, 0, 0, 1, 32'h8000_0000);
            1: apply_setting(1000000, 1000000, 1000000, 65535, 0, 32'h7FFF_FFFF);
            default: begin
               home_pick = $urandom_range(60) - 30;
               apply_setting($urandom_range(4), $urandom_range(4), $urandom_range(40),
                             $urandom_range(8), 32'($urandom_range(99) < 75), home_pick);
            end
         endcase
         case (phase % 4)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 67; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 67; end
            default: begin send_idle_pct = 8; rsp_stall_pct = 8; end
         endcase
         base = items_queued;
         if (phase == 4) begin
            // hold the sender until every outstanding result is back
            while (items_queued - base < PHASE_WORDS / 2)
               queue_episode();
            wait_drained();
         end
         while (items_queued - base < PHASE_WORDS)
            queue_episode();
         wait_drained();
      end

      repeat (8) @(posedge clock);
      mismatches += focuser_outputs_due.size();
      $display("covered %0d words over %0d register settings and four idling patterns",
               items_queued, PHASE_COUNT + 1);
      $display("saw %0d limit resyncs and %0d homing stops", resync_count, homing_stops);
      if (mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ===== stepper_focuser_position_control_core.f =====
sv/sfpc_pkg.sv
sv/stepper_focuser_position_control_core.sv
bench/tb_stepper_focuser_position_control_core.sv
